// ===== rtl/bba_pkg.sv =====
// shared constants, types and codes of the bitmap block allocator
`default_nettype none

package bba_pkg;

  // bitmap geometry
  localparam int unsigned BITMAP_BITS = 32768;
  localparam int unsigned WORD_W      = 64;
  localparam int unsigned BIT_W       = $clog2(WORD_W);
  localparam int unsigned MAP_WORDS   = (BITMAP_BITS + WORD_W - 1) / WORD_W;
  localparam int unsigned WADDR_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned HINT_W      = $clog2(MAP_WORDS + 1);
  localparam int unsigned IDX_W       = WADDR_W + BIT_W;

  // field widths
  localparam int unsigned ADDR_W   = 28;
  localparam int unsigned TOTAL_W  = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CMP_W    = 32;

  // command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [WORD_W-1:0]   word_t;
  typedef logic [WADDR_W-1:0]  waddr_t;
  typedef logic [HINT_W-1:0]   hint_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [BIT_W-1:0]    bitpos_t;
  typedef logic [ADDR_W-1:0]   addr_t;
  typedef logic [TOTAL_W-1:0]  lim_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [1:0]          op_t;
  typedef logic [QPTR_W-1:0]   qptr_t;
  typedef logic [QCNT_W-1:0]   qcnt_t;

  // configuration register indexes
  localparam logic CFG_TOTAL = 1'b0;
  localparam logic CFG_BASE  = 1'b1;

  localparam lim_t  TOTAL_RESET = 16'd32768;
  localparam addr_t BASE_RESET  = '0;

  // request types
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // result status codes
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_RANGE = 2'd2;

  // classified commands
  localparam op_t OP_ALLOC = 2'd0;
  localparam op_t OP_FREE  = 2'd1;
  localparam op_t OP_RANGE = 2'd2;

  typedef struct packed {
    op_t  op;
    idx_t idx;
  } cmd_t;

  // live configuration as seen by the back end
  typedef struct packed {
    lim_t  lim;
    addr_t base;
  } cfg_view_t;

endpackage

`default_nettype wire

// ===== rtl/bitmap_block_allocator.sv =====
// top level of the first-fit bitmap block allocator
`default_nettype none

// First-fit block allocator over a used-block bitmap held in a 64-bit wide
// memory (one word per 64 blocks, 512 words at the default size). After reset
// the block runs a clearing sweep of the whole bitmap memory, one word per
// cycle, and holds busy high meanwhile; configuration writes are taken at
// any time. A request is taken when start is high and busy is low, and lands
// in a two-entry command queue; busy rises only once both entries wait behind
// the request the back end is working on, so from idle at least three
// requests go in back to back. The back end works one request at a time. A
// free reads its word and then writes it back with the bit cleared
// (read-modify-write); an out-of-range free is answered straight from idle.
// An allocate reads and checks words one by one, starting from a hint that
// marks the lowest word that may still have a clear bit; frees move the hint
// back down. When the map is known full an allocate is answered straight
// from idle, with no word read. Each result shows on the out_ ports for
// exactly one cycle with out_strobe high; the receiver cannot stall the
// block, so it must take every beat as it comes.

module bitmap_block_allocator (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // configuration write channel
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic                   cfg_index,
  input  wire bba_pkg::addr_t         cfg_wdata,
  // request channel
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic                   in_req_type,
  input  wire bba_pkg::addr_t         in_free_addr,
  // result channel
  output logic                        out_strobe,
  output bba_pkg::status_t            out_status,
  output bba_pkg::addr_t              out_granted_addr
);

  // queue handshake between front and back
  logic               q_push, q_full, q_pop, q_empty;
  bba_pkg::cmd_t      q_din, q_dout;
  bba_pkg::cfg_view_t cfg_view;
  logic               clearing;

  // front: config registers and request classification
  bba_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .start        (start),
    .busy         (busy),
    .in_req_type  (in_req_type),
    .in_free_addr (in_free_addr),
    .clearing     (clearing),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (q_din),
    .cfg_view     (cfg_view)
  );

  // classified commands wait here while the back end scans
  bba_fifo u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  // back: bitmap memory, scan and result beat
  bba_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_cmd            (q_dout),
    .q_pop            (q_pop),
    .cfg_view         (cfg_view),
    .clearing         (clearing),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_granted_addr (out_granted_addr)
  );

endmodule

`default_nettype wire

// ===== rtl/bba_ram.sv =====
// generic single write, single read ram with registered read data
`default_nettype none

module bba_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 512
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bba_fifo.sv =====
// short command queue between the front and back ends
`default_nettype none

module bba_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire bba_pkg::cmd_t din,
  output logic               full,
  input  wire logic          pop,
  output bba_pkg::cmd_t      dout,
  output logic               empty
);

  bba_pkg::cmd_t  ent_r [bba_pkg::QUEUE_DEPTH];
  bba_pkg::qptr_t wr_ptr_r, wr_ptr_nxt;
  bba_pkg::qptr_t rd_ptr_r, rd_ptr_nxt;
  bba_pkg::qcnt_t cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full    = (cnt_r == bba_pkg::qcnt_t'(bba_pkg::QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == bba_pkg::qptr_t'(bba_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == bba_pkg::qptr_t'(bba_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= din;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bba_front.sv =====
// front end: configuration registers, request acceptance and range check
`default_nettype none

module bba_front (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic                   cfg_index,
  input  wire bba_pkg::addr_t         cfg_wdata,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic                   in_req_type,
  input  wire bba_pkg::addr_t         in_free_addr,
  input  wire logic                   clearing,
  input  wire logic                   q_full,
  output logic                        q_push,
  output bba_pkg::cmd_t               q_cmd,
  output bba_pkg::cfg_view_t          cfg_view
);

  bba_pkg::lim_t  total_r, total_nxt;
  bba_pkg::addr_t base_r, base_nxt;
  bba_pkg::lim_t  lim;
  bba_pkg::addr_t diff;
  logic           in_range;

  assign cfg_ready = 1'b1;

  always_comb begin
    total_nxt = total_r;
    base_nxt  = base_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bba_pkg::CFG_TOTAL: total_nxt = cfg_wdata[bba_pkg::TOTAL_W-1:0];
        bba_pkg::CFG_BASE:  base_nxt  = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= bba_pkg::TOTAL_RESET;
      base_r  <= bba_pkg::BASE_RESET;
    end else begin
      total_r <= total_nxt;
      base_r  <= base_nxt;
    end
  end

  // usable limit never exceeds the bitmap size
  assign lim = (bba_pkg::CMP_W'(total_r) > bba_pkg::CMP_W'(bba_pkg::BITMAP_BITS)) ?
               bba_pkg::lim_t'(bba_pkg::BITMAP_BITS) : total_r;

  assign cfg_view.lim  = lim;
  assign cfg_view.base = base_r;

  assign diff     = in_free_addr - base_r;
  assign in_range = (in_free_addr >= base_r) &&
                    (bba_pkg::CMP_W'(diff) < bba_pkg::CMP_W'(lim));

  assign busy   = clearing || q_full;
  assign q_push = start && !busy;

  always_comb begin
    q_cmd.idx = diff[bba_pkg::IDX_W-1:0];
    if (in_req_type == bba_pkg::REQ_ALLOC) begin
      q_cmd.op = bba_pkg::OP_ALLOC;
    end else if (in_range) begin
      q_cmd.op = bba_pkg::OP_FREE;
    end else begin
      q_cmd.op = bba_pkg::OP_RANGE;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bba_back.sv =====
// back end: bitmap memory, clearing sweep, word scan and result register
`default_nettype none

module bba_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_empty,
  input  wire bba_pkg::cmd_t      q_cmd,
  output logic                    q_pop,
  input  wire bba_pkg::cfg_view_t cfg_view,
  output logic                    clearing,
  output logic                    out_strobe,
  output bba_pkg::status_t        out_status,
  output bba_pkg::addr_t          out_granted_addr
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ARD   = 3'd2;
  localparam logic [2:0] S_ACHK  = 3'd3;
  localparam logic [2:0] S_FRD   = 3'd4;
  localparam logic [2:0] S_FWR   = 3'd5;

  logic [2:0]        state_r, state_nxt;
  bba_pkg::waddr_t   clr_cnt_r, clr_cnt_nxt;
  bba_pkg::waddr_t   scan_r, scan_nxt;
  bba_pkg::hint_t    hint_r, hint_nxt;
  bba_pkg::idx_t     cmd_r, cmd_nxt;
  logic              out_valid_r, out_valid_nxt;
  bba_pkg::status_t  out_status_r, out_status_nxt;
  bba_pkg::addr_t    out_addr_r, out_addr_nxt;

  logic              ram_we, ram_re;
  bba_pkg::waddr_t   ram_waddr, ram_raddr;
  bba_pkg::word_t    ram_wdata, ram_rdata;

  bba_pkg::waddr_t   word_sel;
  bba_pkg::bitpos_t  bit_sel;
  bba_pkg::bitpos_t  zero_bit;
  bba_pkg::idx_t     found_idx;

  // position of the lowest clear bit of a word
  function automatic bba_pkg::bitpos_t lowest_zero(input bba_pkg::word_t w);
    bba_pkg::bitpos_t pos;
    pos = '0;
    for (int i = bba_pkg::WORD_W - 1; i >= 0; i--) begin
      if (!w[i]) begin
        pos = bba_pkg::bitpos_t'(i);
      end
    end
    return pos;
  endfunction

  bba_ram #(
    .WIDTH (bba_pkg::WORD_W),
    .DEPTH (bba_pkg::MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign word_sel  = cmd_r[bba_pkg::IDX_W-1:bba_pkg::BIT_W];
  assign bit_sel   = cmd_r[bba_pkg::BIT_W-1:0];
  assign zero_bit  = lowest_zero(ram_rdata);
  assign found_idx = {scan_r, zero_bit};

  assign clearing         = (state_r == S_CLEAR);
  assign out_strobe       = out_valid_r;
  assign out_status       = out_status_r;
  assign out_granted_addr = out_addr_r;

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    scan_nxt       = scan_r;
    hint_nxt       = hint_r;
    cmd_nxt        = cmd_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    q_pop          = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = clr_cnt_r;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = scan_r;

    case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1;
        if (clr_cnt_r == bba_pkg::waddr_t'(bba_pkg::MAP_WORDS - 1)) begin
          clr_cnt_nxt = '0;
          hint_nxt    = '0;
          state_nxt   = S_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd.idx;
          case (q_cmd.op)
            bba_pkg::OP_ALLOC: begin
              if (hint_r == bba_pkg::hint_t'(bba_pkg::MAP_WORDS)) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = bba_pkg::ST_FULL;
                out_addr_nxt   = '0;
              end else begin
                scan_nxt  = hint_r[bba_pkg::WADDR_W-1:0];
                state_nxt = S_ARD;
              end
            end
            bba_pkg::OP_FREE: begin
              state_nxt = S_FRD;
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = bba_pkg::ST_RANGE;
              out_addr_nxt   = '0;
            end
          endcase
        end
      end

      S_ARD: begin
        ram_re    = 1'b1;
        ram_raddr = scan_r;
        state_nxt = S_ACHK;
      end

      S_ACHK: begin
        if (ram_rdata != '1) begin
          // every word below this one is full
          hint_nxt      = bba_pkg::hint_t'(scan_r);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (bba_pkg::CMP_W'(found_idx) < bba_pkg::CMP_W'(cfg_view.lim)) begin
            ram_we         = 1'b1;
            ram_waddr      = scan_r;
            ram_wdata      = ram_rdata | (bba_pkg::word_t'(1) << zero_bit);
            out_status_nxt = bba_pkg::ST_OK;
            out_addr_nxt   = cfg_view.base + bba_pkg::addr_t'(found_idx);
          end else begin
            out_status_nxt = bba_pkg::ST_FULL;
            out_addr_nxt   = '0;
          end
        end else if (scan_r == bba_pkg::waddr_t'(bba_pkg::MAP_WORDS - 1)) begin
          hint_nxt       = bba_pkg::hint_t'(bba_pkg::MAP_WORDS);
          out_valid_nxt  = 1'b1;
          out_status_nxt = bba_pkg::ST_FULL;
          out_addr_nxt   = '0;
          state_nxt      = S_IDLE;
        end else begin
          scan_nxt  = scan_r + 1'b1;
          hint_nxt  = bba_pkg::hint_t'(scan_r) + 1'b1;
          state_nxt = S_ARD;
        end
      end

      S_FRD: begin
        ram_re    = 1'b1;
        ram_raddr = word_sel;
        state_nxt = S_FWR;
      end

      S_FWR: begin
        ram_we    = 1'b1;
        ram_waddr = word_sel;
        ram_wdata = ram_rdata & ~(bba_pkg::word_t'(1) << bit_sel);
        if (bba_pkg::hint_t'(word_sel) < hint_r) begin
          hint_nxt = bba_pkg::hint_t'(word_sel);
        end
        out_valid_nxt  = 1'b1;
        out_status_nxt = bba_pkg::ST_OK;
        out_addr_nxt   = '0;
        state_nxt      = S_IDLE;
      end

      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      hint_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      hint_r      <= hint_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r       <= scan_nxt;
    cmd_r        <= cmd_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
  end

endmodule

`default_nettype wire
